// File: sv/lru_page_replacement_unit_defines.svh
// Assertion macros for the LRU page replacement unit.
// No dependencies; included by the top level, which provides clk and arst_n.
`ifndef LRU_PAGE_REPLACEMENT_UNIT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lru page replacement: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LPR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lru page replacement: next-cycle check failed");

`endif

// File: sv/lrupr_pkg.sv
// Shared constants and control structs for the LRU page replacement unit.
// No dependencies; imported by lrupr_cell and lru_page_replacement_unit.
package lrupr_pkg;

	localparam int unsigned CFG_W   = 5;   // frames_in_use register width
	localparam int unsigned FRAME_W = 4;   // frame index field on the result
	localparam int unsigned COUNT_W = 32;  // fault counter width

	localparam logic [CFG_W-1:0]   FIU_RESET = 5'd16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Running lookup summary handed from cell to cell.
	typedef struct packed {
		logic found;    // a matching resident page was seen
		logic empty;    // an empty active frame was seen
		logic lru_any;  // lru candidate holds an active frame
	} lru_flags_t;

	// Update broadcast to every cell at the end of a lookup.
	typedef struct packed {
		logic en;         // apply the update this cycle
		logic write;      // miss: victim frame takes the new page
		logic was_valid;  // victim frame held a page before
	} upd_ctl_t;

endpackage

// File: sv/lru_page_replacement_unit.sv
// Top level of the fully associative LRU page replacement unit.
// Depends on lrupr_pkg, lrupr_cell and lru_page_replacement_unit_defines.svh.
//
// Usage:
//  - Reference channel: drive page and raise start. The transaction is taken at
//    a rising edge with start high and busy low. busy then stays high until the
//    lookup and update are finished.
//  - Result channel: done is high for exactly one cycle, with hit, frame,
//    evicted_valid, evicted_page and fault_count valid in that cycle. The
//    receiver cannot stall; it must take the result in that cycle.
//  - Config channel: cfg_valid/cfg_ready write frames_in_use (cfg_ready is
//    always high). Write only while the unit is idle. 0 acts as 1, values above
//    FRAMES act as FRAMES.
//  - Flow: a reference is taken only once the last one has finished. The lookup
//    token walks the row of FRAMES cells, one cell per cycle, then the recency
//    update is applied, then done rises. A new start is taken in the same cycle
//    that done is shown.
//  - Reset: all frames empty, ranks zero, fault count zero, frames_in_use 16.
//    No clearing pass is needed; frame pages are only read once valid.
`include "lru_page_replacement_unit_defines.svh"

module lru_page_replacement_unit #(
	parameter int unsigned FRAMES    = 16,
	parameter int unsigned PAGE_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// reference channel
	input  logic                             start,
	output logic                             busy,
	input  logic [PAGE_BITS-1:0]             page,
	// result channel
	output logic                             done,
	output logic                             hit,
	output logic [lrupr_pkg::FRAME_W-1:0]    frame,
	output logic                             evicted_valid,
	output logic [PAGE_BITS-1:0]             evicted_page,
	output logic [lrupr_pkg::COUNT_W-1:0]    fault_count,
	// config channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lrupr_pkg::CFG_W-1:0]      cfg_data
);
	import lrupr_pkg::*;

	localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int unsigned CNT_W = $clog2(FRAMES + 1);
	localparam int unsigned CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	// control and config registers
	logic                 busy_q, go_q, done_q;
	logic [CFG_W-1:0]     fiu_q;
	logic [COUNT_W-1:0]   faults_q;
	logic [PAGE_BITS-1:0] page_q;

	// result registers
	logic                 hit_q, ev_valid_q;
	logic [FRAME_W-1:0]   frame_q;
	logic [PAGE_BITS-1:0] ev_page_q;

	logic                 accept;
	logic [CW-1:0]        fiu_x, fiu_n;
	logic [FRAMES-1:0]    active;

	// lookup chain, link 0 is fed from here, link FRAMES is the final summary
	logic                 tok_c      [FRAMES+1];
	lru_flags_t           flags_c    [FRAMES+1];
	logic [IDX_W-1:0]     hit_idx_c  [FRAMES+1];
	logic [IDX_W-1:0]     hit_rank_c [FRAMES+1];
	logic [IDX_W-1:0]     empty_idx_c[FRAMES+1];
	logic [IDX_W-1:0]     lru_idx_c  [FRAMES+1];
	logic [IDX_W-1:0]     lru_rank_c [FRAMES+1];
	logic [PAGE_BITS-1:0] lru_page_c [FRAMES+1];

	// update broadcast
	upd_ctl_t             upd;
	logic [IDX_W-1:0]     victim, old_rank;
	logic                 fin, fin_hit, fin_evict;

	assign accept    = start && !busy_q;
	assign busy      = busy_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= FIU_RESET;
		end else if (cfg_valid && cfg_ready) begin
			fiu_q <= cfg_data;
		end
	end

	// clamp frames_in_use into 1..FRAMES, then mark active cells
	always_comb begin
		fiu_x = CW'(fiu_q);
		fiu_n = fiu_x;
		if (fiu_x == '0) begin
			fiu_n = CW'(1);
		end else if (fiu_x > CW'(FRAMES)) begin
			fiu_n = CW'(FRAMES);
		end
	end

	for (genvar i = 0; i < FRAMES; i++) begin : g_act
		assign active[i] = (fiu_n > CW'(i));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			go_q   <= 1'b0;
		end else begin
			go_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= page;
		end
	end

	// head of the chain: empty summary
	assign tok_c[0]       = go_q;
	assign flags_c[0]     = '0;
	assign hit_idx_c[0]   = '0;
	assign hit_rank_c[0]  = '0;
	assign empty_idx_c[0] = '0;
	assign lru_idx_c[0]   = '0;
	assign lru_rank_c[0]  = '0;
	assign lru_page_c[0]  = '0;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		lrupr_cell #(
			.PAGE_BITS (PAGE_BITS),
			.IDX_W     (IDX_W),
			.IDX       (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.active      (active[i]),
			.query       (page_q),
			.tok_i       (tok_c[i]),
			.flags_i     (flags_c[i]),
			.hit_idx_i   (hit_idx_c[i]),
			.hit_rank_i  (hit_rank_c[i]),
			.empty_idx_i (empty_idx_c[i]),
			.lru_idx_i   (lru_idx_c[i]),
			.lru_rank_i  (lru_rank_c[i]),
			.lru_page_i  (lru_page_c[i]),
			.tok_o       (tok_c[i+1]),
			.flags_o     (flags_c[i+1]),
			.hit_idx_o   (hit_idx_c[i+1]),
			.hit_rank_o  (hit_rank_c[i+1]),
			.empty_idx_o (empty_idx_c[i+1]),
			.lru_idx_o   (lru_idx_c[i+1]),
			.lru_rank_o  (lru_rank_c[i+1]),
			.lru_page_o  (lru_page_c[i+1]),
			.upd         (upd),
			.upd_idx     (victim),
			.upd_rank    (old_rank)
		);
	end

	// pick the frame: hit first, then lowest empty frame, then the oldest
	assign fin       = tok_c[FRAMES];
	assign fin_hit   = flags_c[FRAMES].found;
	assign fin_evict = !fin_hit && !flags_c[FRAMES].empty;

	always_comb begin
		if (fin_hit) begin
			victim   = hit_idx_c[FRAMES];
			old_rank = hit_rank_c[FRAMES];
		end else if (flags_c[FRAMES].empty) begin
			victim   = empty_idx_c[FRAMES];
			old_rank = lru_rank_c[FRAMES];
		end else begin
			victim   = lru_idx_c[FRAMES];
			old_rank = lru_rank_c[FRAMES];
		end
	end

	assign upd.en        = fin;
	assign upd.write     = !fin_hit;
	assign upd.was_valid = fin_hit || fin_evict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			faults_q <= '0;
		end else begin
			done_q <= fin;
			if (fin && !fin_hit && (faults_q != COUNT_MAX)) begin
				faults_q <= faults_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			hit_q      <= fin_hit;
			frame_q    <= FRAME_W'(victim);
			ev_valid_q <= fin_evict;
			ev_page_q  <= fin_evict ? lru_page_c[FRAMES] : '0;
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign frame         = frame_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign fault_count   = faults_q;

	// checks
	`LPR_ASSERT_NOW(a_done_idle, done, !busy_q)
	`LPR_ASSERT_NEXT(a_accept_busy, accept, busy_q && tok_c[0])
	`LPR_ASSERT_NOW(a_evict_miss, done && evicted_valid, !hit)
	`LPR_ASSERT_NOW(a_miss_counted, done && !hit, fault_count != '0)
	`LPR_ASSERT_NOW(a_one_token, busy_q, $onehot0({done_q, go_q, fin}))

endmodule

// File: sv/lrupr_cell.sv
// One frame cell: page, valid and recency rank, plus one link of the lookup chain.
// Depends on lrupr_pkg.
module lrupr_cell #(
	parameter int unsigned PAGE_BITS = 16,
	parameter int unsigned IDX_W     = 4,
	parameter int unsigned IDX       = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  active,
	input  logic [PAGE_BITS-1:0]  query,
	input  logic                  tok_i,
	input  lrupr_pkg::lru_flags_t flags_i,
	input  logic [IDX_W-1:0]      hit_idx_i,
	input  logic [IDX_W-1:0]      hit_rank_i,
	input  logic [IDX_W-1:0]      empty_idx_i,
	input  logic [IDX_W-1:0]      lru_idx_i,
	input  logic [IDX_W-1:0]      lru_rank_i,
	input  logic [PAGE_BITS-1:0]  lru_page_i,
	output logic                  tok_o,
	output lrupr_pkg::lru_flags_t flags_o,
	output logic [IDX_W-1:0]      hit_idx_o,
	output logic [IDX_W-1:0]      hit_rank_o,
	output logic [IDX_W-1:0]      empty_idx_o,
	output logic [IDX_W-1:0]      lru_idx_o,
	output logic [IDX_W-1:0]      lru_rank_o,
	output logic [PAGE_BITS-1:0]  lru_page_o,
	input  lrupr_pkg::upd_ctl_t   upd,
	input  logic [IDX_W-1:0]      upd_idx,
	input  logic [IDX_W-1:0]      upd_rank
);
	import lrupr_pkg::*;

	localparam logic [IDX_W-1:0] ME = IDX_W'(IDX);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic [IDX_W-1:0]     rank_q;

	lru_flags_t           flags_n;
	logic [IDX_W-1:0]     hit_idx_n, hit_rank_n, empty_idx_n, lru_idx_n, lru_rank_n;
	logic [PAGE_BITS-1:0] lru_page_n;
	logic                 is_me;

	// fold this frame into the running summary
	always_comb begin
		flags_n     = flags_i;
		hit_idx_n   = hit_idx_i;
		hit_rank_n  = hit_rank_i;
		empty_idx_n = empty_idx_i;
		lru_idx_n   = lru_idx_i;
		lru_rank_n  = lru_rank_i;
		lru_page_n  = lru_page_i;
		if (active && valid_q && (page_q == query) && !flags_i.found) begin
			flags_n.found = 1'b1;
			hit_idx_n     = ME;
			hit_rank_n    = rank_q;
		end
		if (active && !valid_q && !flags_i.empty) begin
			flags_n.empty = 1'b1;
			empty_idx_n   = ME;
		end
		// strict compare: lower index wins a tie
		if (active && (!flags_i.lru_any || (rank_q > lru_rank_i))) begin
			flags_n.lru_any = 1'b1;
			lru_idx_n       = ME;
			lru_rank_n      = rank_q;
			lru_page_n      = page_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_o <= 1'b0;
		end else begin
			tok_o <= tok_i;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_i) begin
			flags_o     <= flags_n;
			hit_idx_o   <= hit_idx_n;
			hit_rank_o  <= hit_rank_n;
			empty_idx_o <= empty_idx_n;
			lru_idx_o   <= lru_idx_n;
			lru_rank_o  <= lru_rank_n;
			lru_page_o  <= lru_page_n;
		end
	end

	assign is_me = (upd_idx == ME);

	// recency update: victim goes to rank 0, younger valid frames age by one (all valid frames if the victim was empty)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd.en) begin
			if (is_me) begin
				rank_q <= '0;
				if (upd.write) begin
					valid_q <= 1'b1;
				end
			end else if (valid_q && (!upd.was_valid || (rank_q < upd_rank))) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en && upd.write && is_me) begin
			page_q <= query;
		end
	end

endmodule
